[rtl/core/thv_pkg.sv]
// Shared types, field offsets, codes and byte classifiers for the tar header validator.
`timescale 1ns / 1ps

package thv_pkg;

	localparam int HdrLen    = 512;
	localparam int OffW      = $clog2(HdrLen);
	localparam int ChkOff    = 148;
	localparam int ChkLen    = 8;
	localparam int SizeOff   = 124;
	localparam int SizeLen   = 12;
	localparam int MagicOff  = 257;
	localparam int MagicLen  = 5;
	localparam int MagicIdxW = 3;
	localparam int SumW      = 17;
	localparam int SumBias   = 256;
	localparam int StoredW   = 24;
	localparam int SizeW     = 64;

	// Queue between front and back.
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = QPtrW + 1;

	localparam logic [7:0] B256Flag = 8'h80;
	localparam logic [7:0] B256Neg  = 8'h40;
	localparam logic [7:0] B256Mask = 8'h3F;

	// Checksum field parser phases.
	localparam logic [1:0] SumSkip   = 2'd0;
	localparam logic [1:0] SumDigits = 2'd1;
	localparam logic [1:0] SumDone   = 2'd2;

	// Size field parser phases.
	localparam logic [2:0] SzStart  = 3'd0;
	localparam logic [2:0] SzLead   = 3'd1;
	localparam logic [2:0] SzDigits = 3'd2;
	localparam logic [2:0] SzTrail  = 3'd3;
	localparam logic [2:0] SzDone   = 3'd4;
	localparam logic [2:0] SzB256   = 3'd5;

	// One classified header byte as it travels from front to back.
	typedef struct packed {
		logic [7:0] data;
		logic       chk;        // inside the checksum field
		logic       size_fld;   // inside the size field
		logic       size_first; // first byte of the size field
		logic       magic_bad;  // magic byte that does not match
		logic       ws;         // space or 0x09..0x0D
		logic       oct;        // '0'..'7'
		logic       last;       // byte 511
	} beat_t;

	typedef struct packed {
		logic                 header_ok;
		logic                 magic_ok;
		logic                 checksum_ok;
		logic [StoredW-1:0]   stored_checksum;
		logic [SumW-1:0]      computed_checksum;
		logic                 size_ok;
		logic                 size_base256;
		logic [SizeW-1:0]     size_value;
	} result_t;

	function automatic logic [7:0] magic_char(input logic [MagicIdxW-1:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0:    c = 8'h75; // u
			3'd1:    c = 8'h73; // s
			3'd2:    c = 8'h74; // t
			3'd3:    c = 8'h61; // a
			3'd4:    c = 8'h72; // r
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_ws(input logic [7:0] b);
		return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
	endfunction

	function automatic logic is_oct(input logic [7:0] b);
		return (b >= 8'h30) && (b <= 8'h37);
	endfunction

endpackage

[rtl/core/thv_front.sv]
// Front end: accepts header bytes, counts offsets and tags each beat with its field.
`timescale 1ns / 1ps

module thv_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          header_byte,
	input  logic                q_full,
	output logic                push,
	output thv_pkg::beat_t      beat
);

	logic [thv_pkg::OffW-1:0] off_q;
	logic [thv_pkg::OffW-1:0] magic_diff;
	logic [7:0]               magic_exp;
	logic                     in_magic;

	assign push = in_valid && !q_full;

	// Advance the offset on every accepted beat; it wraps after byte 511.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (push) begin
			off_q <= off_q + 1'b1;
		end
	end

	assign magic_diff = off_q - thv_pkg::OffW'(thv_pkg::MagicOff);
	assign magic_exp  = thv_pkg::magic_char(magic_diff[thv_pkg::MagicIdxW-1:0]);

	always_comb begin
		in_magic = off_q inside {[thv_pkg::MagicOff:thv_pkg::MagicOff + thv_pkg::MagicLen - 1]};
		beat.data       = header_byte;
		beat.chk        = off_q inside {[thv_pkg::ChkOff:thv_pkg::ChkOff + thv_pkg::ChkLen - 1]};
		beat.size_fld   = off_q inside {[thv_pkg::SizeOff:thv_pkg::SizeOff + thv_pkg::SizeLen - 1]};
		beat.size_first = (off_q == thv_pkg::OffW'(thv_pkg::SizeOff));
		beat.magic_bad  = in_magic && (header_byte != magic_exp);
		beat.ws         = thv_pkg::is_ws(header_byte);
		beat.oct        = thv_pkg::is_oct(header_byte);
		beat.last       = (off_q == thv_pkg::OffW'(thv_pkg::HdrLen - 1));
	end

endmodule

[rtl/core/thv_queue.sv]
// Short beat queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module thv_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  thv_pkg::beat_t     push_beat,
	input  logic               pop,
	output logic               full,
	output logic               head_valid,
	output thv_pkg::beat_t     head_beat
);

	thv_pkg::beat_t             mem_q [thv_pkg::QDepth];
	logic [thv_pkg::QPtrW-1:0]  wr_ptr_q;
	logic [thv_pkg::QPtrW-1:0]  rd_ptr_q;
	logic [thv_pkg::QCntW-1:0]  count_q;

	assign full       = (count_q == thv_pkg::QCntW'(thv_pkg::QDepth));
	assign head_valid = (count_q != '0);
	assign head_beat  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !head_valid) && !(push && full))
		else $error("queue overrun or underrun");

endmodule

[rtl/core/thv_back.sv]
// Back end: runs the checksum, size and magic parsers and holds the result beat.
`timescale 1ns / 1ps

module thv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  thv_pkg::beat_t     head_beat,
	output logic               pop,
	input  logic               out_stall,
	output logic               out_valid,
	output thv_pkg::result_t   res
);

	logic [thv_pkg::SumW-1:0]    sum_q, sum_d;
	logic [thv_pkg::StoredW-1:0] stored_q, stored_d;
	logic [1:0]                  sum_ph_q, sum_ph_d;
	logic [thv_pkg::SizeW-1:0]   acc_q, acc_d;
	logic [2:0]                  sz_ph_q, sz_ph_d;
	logic                        fail_q, fail_d;
	logic                        seen_q, seen_d;
	logic                        b256_q, b256_d;
	logic                        magic_q, magic_d;
	logic                        out_valid_q;
	thv_pkg::result_t            res_q, res_d;

	logic [2:0]                  oct_ph;
	logic                        do_oct;
	logic [thv_pkg::SumW-1:0]    total;
	logic                        ok_sum;
	logic                        ok_size;
	logic                        last_pop;

	// Hold a last beat while a previous result still waits downstream.
	assign pop      = head_valid && (!head_beat.last || !out_valid_q || !out_stall);
	assign last_pop = pop && head_beat.last;

	always_comb begin
		sum_d    = sum_q;
		stored_d = stored_q;
		sum_ph_d = sum_ph_q;
		acc_d    = acc_q;
		sz_ph_d  = sz_ph_q;
		fail_d   = fail_q;
		seen_d   = seen_q;
		b256_d   = b256_q;
		magic_d  = magic_q;
		do_oct   = 1'b0;
		oct_ph   = sz_ph_q;

		// Checksum field is parsed, everything else is summed.
		if (head_beat.chk) begin
			if (sum_ph_q != thv_pkg::SumDone) begin
				if (sum_ph_q == thv_pkg::SumSkip && head_beat.ws) begin
					sum_ph_d = sum_ph_q;
				end else if (head_beat.oct) begin
					stored_d = {stored_q[thv_pkg::StoredW-4:0], head_beat.data[2:0]};
					sum_ph_d = thv_pkg::SumDigits;
				end else begin
					sum_ph_d = thv_pkg::SumDone;
				end
			end
		end else begin
			sum_d = sum_q + thv_pkg::SumW'(head_beat.data);
		end

		if (head_beat.size_fld && sz_ph_q != thv_pkg::SzDone) begin
			if (head_beat.size_first) begin
				if (head_beat.data[7]) begin
					b256_d = 1'b1;
					if ((head_beat.data & thv_pkg::B256Neg) != 8'h00) begin
						fail_d  = 1'b1;
						sz_ph_d = thv_pkg::SzDone;
					end else begin
						acc_d   = thv_pkg::SizeW'(head_beat.data & thv_pkg::B256Mask);
						sz_ph_d = thv_pkg::SzB256;
					end
				end else if (head_beat.data == 8'h00) begin
					sz_ph_d = thv_pkg::SzLead;
				end else begin
					do_oct = 1'b1;
					oct_ph = thv_pkg::SzLead;
				end
			end else if (sz_ph_q == thv_pkg::SzB256) begin
				// Drop the decode if another byte would push bits past 64.
				if (acc_q[thv_pkg::SizeW-1:thv_pkg::SizeW-8] != 8'h00) begin
					fail_d  = 1'b1;
					sz_ph_d = thv_pkg::SzDone;
				end else begin
					acc_d = {acc_q[thv_pkg::SizeW-9:0], head_beat.data};
				end
			end else begin
				do_oct = 1'b1;
			end
		end

		if (do_oct) begin
			sz_ph_d = oct_ph;
			if (head_beat.oct) begin
				if (oct_ph == thv_pkg::SzTrail) begin
					fail_d  = 1'b1;
					sz_ph_d = thv_pkg::SzDone;
				end else begin
					acc_d   = {acc_q[thv_pkg::SizeW-4:0], head_beat.data[2:0]};
					seen_d  = 1'b1;
					sz_ph_d = thv_pkg::SzDigits;
				end
			end else if (head_beat.data == 8'h00) begin
				sz_ph_d = thv_pkg::SzDone;
			end else if (head_beat.ws) begin
				if (oct_ph == thv_pkg::SzDigits) begin
					sz_ph_d = thv_pkg::SzTrail;
				end
			end else begin
				fail_d  = 1'b1;
				sz_ph_d = thv_pkg::SzDone;
			end
		end

		if (head_beat.magic_bad) begin
			magic_d = 1'b0;
		end
	end

	// The sum register starts at the bias, so the last byte's add gives the total.
	assign total   = sum_q + thv_pkg::SumW'(head_beat.data);
	assign ok_sum  = (stored_q == thv_pkg::StoredW'(total));
	assign ok_size = !fail_q && (b256_q || seen_q);

	always_comb begin
		res_d.header_ok         = magic_q && ok_sum;
		res_d.magic_ok          = magic_q;
		res_d.checksum_ok       = ok_sum;
		res_d.stored_checksum   = stored_q;
		res_d.computed_checksum = total;
		res_d.size_ok           = ok_size;
		res_d.size_base256      = b256_q;
		res_d.size_value        = ok_size ? acc_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= thv_pkg::SumW'(thv_pkg::SumBias);
			stored_q <= '0;
			sum_ph_q <= thv_pkg::SumSkip;
			acc_q    <= '0;
			sz_ph_q  <= thv_pkg::SzStart;
			fail_q   <= 1'b0;
			seen_q   <= 1'b0;
			b256_q   <= 1'b0;
			magic_q  <= 1'b1;
		end else if (last_pop) begin
			sum_q    <= thv_pkg::SumW'(thv_pkg::SumBias);
			stored_q <= '0;
			sum_ph_q <= thv_pkg::SumSkip;
			acc_q    <= '0;
			sz_ph_q  <= thv_pkg::SzStart;
			fail_q   <= 1'b0;
			seen_q   <= 1'b0;
			b256_q   <= 1'b0;
			magic_q  <= 1'b1;
		end else if (pop) begin
			sum_q    <= sum_d;
			stored_q <= stored_d;
			sum_ph_q <= sum_ph_d;
			acc_q    <= acc_d;
			sz_ph_q  <= sz_ph_d;
			fail_q   <= fail_d;
			seen_q   <= seen_d;
			b256_q   <= b256_d;
			magic_q  <= magic_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_pop) begin
			res_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign res       = res_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_q.size_ok |-> res_q.size_value == '0)
		else $error("size value not cleared on failed decode");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> res_q.header_ok == (res_q.magic_ok && res_q.checksum_ok))
		else $error("header flag disagrees with magic and checksum flags");

	assert property (@(posedge clk) disable iff (!arst_n)
		last_pop |=> sum_q == thv_pkg::SumW'(thv_pkg::SumBias) && magic_q && !fail_q
			&& sz_ph_q == thv_pkg::SzStart && sum_ph_q == thv_pkg::SumSkip)
		else $error("parser state not restored after last byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !last_pop)
		else $error("result overwritten while still stalled");

endmodule

[rtl/core/tar_header_validator_core.sv]
// Top level of the tar header validator: front end, beat queue and back end.
`timescale 1ns / 1ps

// Streams a 512-byte ustar header in one byte per beat and emits one result beat
// after every 512th input beat; there is no framing search, so every group of 512
// bytes after reset is one header. The block sustains one byte per clock while
// in_stall is low: the front end tags each beat with its field and pushes it into
// a four-entry queue, and the back end pops one beat per clock while one waits and
// updates the checksum sum, the octal checksum parser, the size decoder (strict
// octal or base-256) and the magic check. Once byte 511 is accepted, its result
// passes through the queue entry and the output valid register to out_valid, and sits
// in an output register, so bytes of the next header keep flowing while it waits;
// only the next header's last byte waits if that result is still stalled, and
// in_stall rises once the queue fills behind it.
// computed_checksum is the sum of all bytes outside the checksum field plus 256,
// modulo 2^17; size_value reads zero whenever size_ok is low.

module tar_header_validator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  header_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        header_ok,
	output logic        magic_ok,
	output logic        checksum_ok,
	output logic [23:0] stored_checksum,
	output logic [16:0] computed_checksum,
	output logic        size_ok,
	output logic        size_base256,
	output logic [63:0] size_value
);

	logic               push;
	logic               q_full;
	logic               pop;
	logic               head_valid;
	thv_pkg::beat_t     push_beat;
	thv_pkg::beat_t     head_beat;
	thv_pkg::result_t   res;

	// Stall the input beat only when the queue has no room.
	assign in_stall = q_full;

	thv_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.header_byte (header_byte),
		.q_full      (q_full),
		.push        (push),
		.beat        (push_beat)
	);

	thv_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_beat  (push_beat),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_beat  (head_beat)
	);

	thv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_beat  (head_beat),
		.pop        (pop),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.res        (res)
	);

	// Unpack the held result onto the output field ports.
	assign header_ok         = res.header_ok;
	assign magic_ok          = res.magic_ok;
	assign checksum_ok       = res.checksum_ok;
	assign stored_checksum   = res.stored_checksum;
	assign computed_checksum = res.computed_checksum;
	assign size_ok           = res.size_ok;
	assign size_base256      = res.size_base256;
	assign size_value        = res.size_value;

endmodule
